// ===== src/rrco_pkg.sv =====
// Shared constants, widths and helpers for the rotated rectangle / circle overlap test.
// No dependencies.
package rrco_pkg;

    localparam int TRIG_FRAC_BITS  = 14;
    localparam int COORD_FRAC_BITS = 4;
    localparam int SCALE_BITS      = TRIG_FRAC_BITS + COORD_FRAC_BITS;

    localparam int POS_W  = 12;
    localparam int SIZE_W = 11;
    localparam int TRIG_W = 16;
    localparam int CRD_W  = 16;
    localparam int RAD_W  = 15;

    // Input request layout inside tdata.
    localparam int LEFT_LSB = 0;
    localparam int TOP_LSB  = LEFT_LSB + POS_W;
    localparam int WID_LSB  = TOP_LSB + POS_W;
    localparam int HGT_LSB  = WID_LSB + SIZE_W;
    localparam int COS_LSB  = HGT_LSB + SIZE_W;
    localparam int SIN_LSB  = COS_LSB + TRIG_W;
    localparam int CX_LSB   = SIN_LSB + TRIG_W;
    localparam int CY_LSB   = CX_LSB + CRD_W;
    localparam int RAD_LSB  = CY_LSB + CRD_W;
    localparam int IN_BITS  = RAD_LSB + RAD_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W    = 8;

    // Rectangle center in whole pixels, offset in coordinate units.
    localparam int CEN_W  = POS_W + 1;
    localparam int DIFF_W = ((CEN_W + COORD_FRAC_BITS) > CRD_W ?
                            (CEN_W + COORD_FRAC_BITS) : CRD_W) + 1;
    localparam int PROD_W = TRIG_W + DIFF_W;
    localparam int ROT_W  = PROD_W + 1;
    localparam int GAP_W  = ROT_W + 1;
    // Half extent at full scale, and the scaled radius.
    localparam int HALF_W = SIZE_W + SCALE_BITS - 1;
    localparam int RR_W   = RAD_W + TRIG_FRAC_BITS;
    localparam int SQ_W   = 2 * RR_W;

    typedef logic signed [GAP_W-1:0] gap_t;

    function automatic logic [GAP_W-1:0] abs_val(input gap_t v);
        abs_val = v[GAP_W-1] ? GAP_W'(-v) : GAP_W'(v);
    endfunction

    // Distance from v to the interval [-lim, lim].
    function automatic logic [GAP_W-1:0] clamp_gap(input gap_t v, input gap_t lim);
        if (v < -lim)
        begin
            clamp_gap = GAP_W'(-lim - v);
        end
        else if (v > lim)
        begin
            clamp_gap = GAP_W'(v - lim);
        end
        else
        begin
            clamp_gap = '0;
        end
    endfunction

endpackage

// ===== src/rotated_rect_circle_overlap.sv =====
// Rotated rectangle / circle overlap test, six register stages, one request per cycle.
// Depends on rrco_pkg.
//
//  channel  | direction | content
//  s_axis   | in        | rectangle, rotation, circle (tdata)
//  m_axis   | out       | hit flag (tdata bit 0)
//
// A request enters every cycle unless the output stalls.
// The squarings of the edge distances (29 x 29 bits) set the stage depth.
// Reset clears only the valid bits; the payload registers are not reset.
// When the result is not taken the whole pipeline holds, so nothing is lost or repeated.
module rotated_rect_circle_overlap
    import rrco_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // left, top, width, height, cos, sin, circle_x, circle_y, radius (from bit 0 up)
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // hit (bit 0), zero fill
    output logic [OUT_W-1:0] m_axis_tdata
);

    logic en;
    logic [6:1] v_reg;

    assign en            = m_axis_tready || !v_reg[6];
    assign s_axis_tready = en;
    assign m_axis_tvalid = v_reg[6];

    // Field extraction.
    logic signed [POS_W-1:0]  left_in, top_in;
    logic        [SIZE_W-1:0] w_in, h_in;
    logic signed [TRIG_W-1:0] cs_in, sn_in;
    logic signed [CRD_W-1:0]  px_in, py_in;
    logic        [RAD_W-1:0]  rad_in;

    assign left_in = s_axis_tdata[LEFT_LSB +: POS_W];
    assign top_in  = s_axis_tdata[TOP_LSB  +: POS_W];
    assign w_in    = s_axis_tdata[WID_LSB  +: SIZE_W];
    assign h_in    = s_axis_tdata[HGT_LSB  +: SIZE_W];
    assign cs_in   = s_axis_tdata[COS_LSB  +: TRIG_W];
    assign sn_in   = s_axis_tdata[SIN_LSB  +: TRIG_W];
    assign px_in   = s_axis_tdata[CX_LSB   +: CRD_W];
    assign py_in   = s_axis_tdata[CY_LSB   +: CRD_W];
    assign rad_in  = s_axis_tdata[RAD_LSB  +: RAD_W];

    // Stage 1: offset from rectangle center.
    logic signed [CEN_W-1:0]  cxw, cyh;
    logic signed [DIFF_W-1:0] dx_next, dy_next, dx_reg, dy_reg;
    logic signed [TRIG_W-1:0] cs1_reg, sn1_reg;
    logic        [SIZE_W-1:0] w1_reg, h1_reg, w2_reg, h2_reg;
    logic        [RAD_W-1:0]  rad1_reg, rad2_reg;

    assign cxw     = CEN_W'(left_in) + $signed({3'b000, w_in[SIZE_W-1:1]});
    assign cyh     = CEN_W'(top_in) + $signed({3'b000, h_in[SIZE_W-1:1]});
    assign dx_next = DIFF_W'(px_in) - (DIFF_W'(cxw) <<< COORD_FRAC_BITS);
    assign dy_next = DIFF_W'(py_in) - (DIFF_W'(cyh) <<< COORD_FRAC_BITS);

    // Stage 2: rotation products.
    logic signed [PROD_W-1:0] pcx_reg, psy_reg, pcy_reg, psx_reg;

    // Stage 3: rotated offset and scaled extents.
    logic signed [ROT_W-1:0] ux_reg, uy_reg;
    logic [HALF_W-1:0] hw3_reg, hh3_reg, iw3_reg, ih3_reg;
    logic [RR_W-1:0]   rr3_reg;

    // Stage 4: distances to the edges.
    logic [RR_W-1:0] gx_reg, gy_reg, axp_reg, axm_reg, ayp_reg, aym_reg, rr4_reg;
    logic [5:0]      lt4_reg;
    logic            ins4_reg;
    gap_t            ux_s, uy_s, hw_s, hh_s;
    logic [GAP_W-1:0] gx_u, gy_u, axp_u, axm_u, ayp_u, aym_u, rr_u;

    assign ux_s = GAP_W'(ux_reg);
    assign uy_s = GAP_W'(uy_reg);
    assign hw_s = gap_t'({1'b0, GAP_W'(hw3_reg)});
    assign hh_s = gap_t'({1'b0, GAP_W'(hh3_reg)});
    assign gx_u  = clamp_gap(ux_s, hw_s);
    assign gy_u  = clamp_gap(uy_s, hh_s);
    assign axp_u = abs_val(ux_s - hw_s);
    assign axm_u = abs_val(ux_s + hw_s);
    assign ayp_u = abs_val(uy_s - hh_s);
    assign aym_u = abs_val(uy_s + hh_s);
    assign rr_u  = GAP_W'(rr3_reg);

    // Stage 5: squares.
    logic [SQ_W-1:0] sgx_reg, sgy_reg, saxp_reg, saxm_reg, sayp_reg, saym_reg, srr_reg;
    logic [5:0]      lt5_reg;
    logic            ins5_reg;

    // Stage 6: per-edge sums and the final decision.
    logic e_top, e_right, e_bot, e_left, hit_next, hit_reg;

    // lt bits: 0 gx, 1 gy, 2 axp, 3 axm, 4 ayp, 5 aym (each below the radius)
    assign e_top   = lt5_reg[0] && lt5_reg[4] && ((SQ_W+1)'(sgx_reg) + (SQ_W+1)'(sayp_reg)
                     < (SQ_W+1)'(srr_reg));
    assign e_right = lt5_reg[2] && lt5_reg[1] && ((SQ_W+1)'(saxp_reg) + (SQ_W+1)'(sgy_reg)
                     < (SQ_W+1)'(srr_reg));
    assign e_bot   = lt5_reg[0] && lt5_reg[5] && ((SQ_W+1)'(sgx_reg) + (SQ_W+1)'(saym_reg)
                     < (SQ_W+1)'(srr_reg));
    assign e_left  = lt5_reg[3] && lt5_reg[1] && ((SQ_W+1)'(saxm_reg) + (SQ_W+1)'(sgy_reg)
                     < (SQ_W+1)'(srr_reg));
    assign hit_next = ins5_reg || e_top || e_right || e_bot || e_left;

    assign m_axis_tdata = {{(OUT_W-1){1'b0}}, hit_reg};

    // v_reg[6] is the output stage; v_reg[5] marks the squarer stage.
    logic [6:1] v_next;
    assign v_next = {v_reg[5:1], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    // Payload path: stage 1 -> 2 -> 3 -> 4 -> squares -> output.
    logic v5in;
    assign v5in = 1'b1;

    always_ff @(posedge clk)
    begin
        if (en && v5in)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            cs1_reg  <= cs_in;
            sn1_reg  <= sn_in;
            w1_reg   <= w_in;
            h1_reg   <= h_in;
            rad1_reg <= rad_in;

            pcx_reg  <= PROD_W'(cs1_reg) * PROD_W'(dx_reg);
            psy_reg  <= PROD_W'(sn1_reg) * PROD_W'(dy_reg);
            pcy_reg  <= PROD_W'(cs1_reg) * PROD_W'(dy_reg);
            psx_reg  <= PROD_W'(sn1_reg) * PROD_W'(dx_reg);
            w2_reg   <= w1_reg;
            h2_reg   <= h1_reg;
            rad2_reg <= rad1_reg;

            ux_reg  <= ROT_W'(pcx_reg) - ROT_W'(psy_reg);
            uy_reg  <= ROT_W'(pcy_reg) + ROT_W'(psx_reg);
            hw3_reg <= HALF_W'(w2_reg) << (SCALE_BITS - 1);
            hh3_reg <= HALF_W'(h2_reg) << (SCALE_BITS - 1);
            iw3_reg <= HALF_W'(w2_reg[SIZE_W-1:1]) << SCALE_BITS;
            ih3_reg <= HALF_W'(h2_reg[SIZE_W-1:1]) << SCALE_BITS;
            rr3_reg <= RR_W'(rad2_reg) << TRIG_FRAC_BITS;

            gx_reg   <= gx_u[RR_W-1:0];
            gy_reg   <= gy_u[RR_W-1:0];
            axp_reg  <= axp_u[RR_W-1:0];
            axm_reg  <= axm_u[RR_W-1:0];
            ayp_reg  <= ayp_u[RR_W-1:0];
            aym_reg  <= aym_u[RR_W-1:0];
            rr4_reg  <= rr3_reg;
            lt4_reg  <= {aym_u < rr_u, ayp_u < rr_u, axm_u < rr_u,
                         axp_u < rr_u, gy_u < rr_u, gx_u < rr_u};
            ins4_reg <= (abs_val(ux_s) < GAP_W'(iw3_reg)) &&
                        (abs_val(uy_s) < GAP_W'(ih3_reg));

            sgx_reg  <= SQ_W'(gx_reg) * SQ_W'(gx_reg);
            sgy_reg  <= SQ_W'(gy_reg) * SQ_W'(gy_reg);
            saxp_reg <= SQ_W'(axp_reg) * SQ_W'(axp_reg);
            saxm_reg <= SQ_W'(axm_reg) * SQ_W'(axm_reg);
            sayp_reg <= SQ_W'(ayp_reg) * SQ_W'(ayp_reg);
            saym_reg <= SQ_W'(aym_reg) * SQ_W'(aym_reg);
            srr_reg  <= SQ_W'(rr4_reg) * SQ_W'(rr4_reg);
            lt5_reg  <= lt4_reg;
            ins5_reg <= ins4_reg;

            hit_reg  <= hit_next;
        end
    end

    // A point that passes the inside test (ins5_reg) always reports a hit.
    a_inside_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v_reg[5] && ins5_reg) |=> (m_axis_tvalid && hit_reg))
        else $error("inside point did not report a hit");

    // With zero radius only the inside test can hit.
    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v_reg[5] && !ins5_reg && srr_reg == '0) |=> !hit_reg)
        else $error("zero radius reported an edge hit");

    // A stalled pipeline keeps every valid bit in place.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("valid bits moved during a stall");

endmodule
